FILE: hdl/ile_pkg.sv
// Indexed list engine package: widths, action codes, cell control types.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package ile_pkg;

  localparam int unsigned DataW       = 64;
  localparam int unsigned PosW        = 16;
  localparam int unsigned ActW        = 3;
  localparam int unsigned DefCapacity = 64;
  localparam int unsigned MaxCapacity = 4096;
  localparam int unsigned IdxW        = $clog2(MaxCapacity + 1);
  localparam int unsigned CntWDef     = $clog2(DefCapacity + 1);

  localparam logic [DataW-1:0] NotFound = {DataW{1'b1}};

  typedef enum logic [ActW-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_GET    = 3'd2,
    ACT_SET    = 3'd3,
    ACT_INSERT = 3'd4,
    ACT_REMOVE = 3'd5,
    ACT_FIND   = 3'd6,
    ACT_CLEAR  = 3'd7
  } act_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef enum logic {
    RD_INDEX,
    RD_MATCH
  } rd_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic              capture;
    logic              sweep;
    cell_op_e          op;
    rd_mode_e          rd;
    logic [IdxW-1:0]   wr_idx;
    logic [IdxW-1:0]   rd_idx;
    logic [IdxW-1:0]   lim;
    logic [DataW-1:0]  val;
  } cell_ctl_t;

  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] data;
  } cell_res_t;

endpackage

FILE: hdl/ile_if.sv
// Request and response channel interfaces of the indexed list engine.
// Depends on ile_pkg.
`timescale 1ns / 1ps

interface ile_req_if;
  logic                                valid;
  logic                                ready;
  logic [ile_pkg::ActW-1:0]            action;
  logic signed [ile_pkg::PosW-1:0]     position;
  logic signed [ile_pkg::DataW-1:0]    operand_value;

  modport source (output valid, action, position, operand_value, input ready);
  modport sink   (input valid, action, position, operand_value, output ready);
endinterface

interface ile_rsp_if #(
  parameter int unsigned CNT_W = ile_pkg::CntWDef
);
  logic                              valid;
  logic                              ready;
  logic signed [ile_pkg::DataW-1:0]  answer;
  logic [CNT_W-1:0]                  entry_count;
  logic                              success;

  modport source (output valid, answer, entry_count, success, input ready);
  modport sink   (input valid, answer, entry_count, success, output ready);
endinterface

FILE: hdl/ile_cell.sv
// One list cell: holds one entry, shifts with its neighbors, and folds the
// read/search result down the chain. Depends on ile_pkg.
`timescale 1ns / 1ps

module ile_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                       clk_i,
  input  ile_pkg::cell_ctl_t         ctl_i,
  input  logic [ile_pkg::DataW-1:0]  below_i,
  input  logic [ile_pkg::DataW-1:0]  above_i,
  input  ile_pkg::cell_res_t         res_above_i,
  output logic [ile_pkg::DataW-1:0]  entry_o,
  output ile_pkg::cell_res_t         res_o
);
  import ile_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);

  logic [DataW-1:0] entry_q, entry_d;
  cell_res_t        res_q, res_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.capture) begin
      case (ctl_i.op)
        CELL_WRITE: begin
          if (MyIdx == ctl_i.wr_idx) entry_d = ctl_i.val;
        end
        CELL_INSERT: begin
          if (MyIdx > ctl_i.wr_idx) begin
            entry_d = below_i;
          end else if (MyIdx == ctl_i.wr_idx) begin
            entry_d = ctl_i.val;
          end
        end
        CELL_REMOVE: begin
          if (MyIdx >= ctl_i.wr_idx) entry_d = above_i;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_d = res_q;
    if (ctl_i.capture) begin
      if (ctl_i.rd == RD_INDEX) begin
        res_d.hit  = (MyIdx == ctl_i.rd_idx);
        res_d.data = entry_q;
      end else begin
        res_d.hit  = (MyIdx < ctl_i.lim) && (entry_q == ctl_i.val);
        res_d.data = DataW'(CELL_IDX);
      end
    end else if (ctl_i.sweep && !res_q.hit) begin
      res_d = res_above_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    res_q   <= res_d;
  end

  assign entry_o = entry_q;
  assign res_o   = res_q;

endmodule

FILE: hdl/indexed_list_engine.sv
// Indexed list engine top: a chain of CAPACITY cells plus the action decoder.
// Push, set, insert, clear go from the idle state straight to the done state.
// Pop, get, remove, find pass through the sweep state while the result folds down
// the cell chain (no sweep when CAPACITY is 1). A new request is taken only in idle.
// Reset empties the list (count 0); entry contents are not cleared.
`timescale 1ns / 1ps

module indexed_list_engine #(
  parameter int unsigned CAPACITY = ile_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ile_req_if.sink     req_i,
  ile_rsp_if.source   rsp_o
);
  import ile_pkg::*;

  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned SweepLen = CAPACITY - 1;

  st_e              state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  sweep_q, sweep_d;
  logic             is_read_q, is_read_d;
  logic             is_find_q, is_find_d;
  logic             ok_q, ok_d;
  logic [DataW-1:0] ans_q, ans_d;

  logic             rsp_valid_q;
  logic [DataW-1:0] rsp_ans_q;
  logic [CntW-1:0]  rsp_cnt_q;
  logic             rsp_ok_q;

  logic             accept;
  logic             out_load;
  cell_ctl_t        ctl;
  act_e             act;
  logic [PosW-1:0]  pos;
  logic [PosW-1:0]  cnt_ext;
  logic             in_range;
  logic             full;
  logic [IdxW-1:0]  ins_at;
  logic [DataW-1:0] done_ans;
  logic             done_ok;

  logic [DataW-1:0] entry_w [CAPACITY];
  cell_res_t        res_w   [CAPACITY];

  assign act      = act_e'(req_i.action);
  assign pos      = req_i.position;
  assign cnt_ext  = PosW'(count_q);
  assign in_range = !pos[PosW-1] && (pos < cnt_ext);
  assign full     = (32'(count_q) == CAPACITY);
  assign accept   = req_i.valid && req_i.ready;

  always_comb begin
    if (pos[PosW-1]) begin
      ins_at = '0;
    end else if (pos > cnt_ext) begin
      ins_at = IdxW'(count_q);
    end else begin
      ins_at = IdxW'(pos);
    end
  end

  // action decode
  always_comb begin
    ctl.capture = accept;
    ctl.sweep   = (state_q == ST_SWEEP);
    ctl.op      = CELL_HOLD;
    ctl.rd      = RD_INDEX;
    ctl.wr_idx  = IdxW'(pos);
    ctl.rd_idx  = IdxW'(pos);
    ctl.lim     = IdxW'(count_q);
    ctl.val     = req_i.operand_value;
    count_d     = count_q;
    ok_d        = 1'b0;
    ans_d       = '0;
    is_read_d   = 1'b0;
    is_find_d   = 1'b0;
    unique case (act)
      ACT_PUSH: begin
        ctl.wr_idx = IdxW'(count_q);
        if (!full) begin
          ctl.op  = CELL_WRITE;
          count_d = count_q + CntW'(1);
          ok_d    = 1'b1;
        end
        ans_d = DataW'(count_d);
      end
      ACT_POP: begin
        is_read_d  = 1'b1;
        ctl.rd_idx = IdxW'(count_q) - IdxW'(1);
        if (count_q != '0) begin
          count_d = count_q - CntW'(1);
          ok_d    = 1'b1;
        end
      end
      ACT_GET: begin
        is_read_d = 1'b1;
        ok_d      = in_range;
      end
      ACT_SET: begin
        if (in_range) begin
          ctl.op = CELL_WRITE;
          ok_d   = 1'b1;
          ans_d  = req_i.operand_value;
        end
      end
      ACT_INSERT: begin
        ctl.wr_idx = ins_at;
        if (!full) begin
          ctl.op  = CELL_INSERT;
          count_d = count_q + CntW'(1);
          ok_d    = 1'b1;
        end
        ans_d = DataW'(count_d);
      end
      ACT_REMOVE: begin
        is_read_d = 1'b1;
        if (in_range) begin
          ctl.op  = CELL_REMOVE;
          count_d = count_q - CntW'(1);
          ok_d    = 1'b1;
        end
      end
      ACT_FIND: begin
        is_read_d = 1'b1;
        is_find_d = 1'b1;
        ctl.rd    = RD_MATCH;
      end
      ACT_CLEAR: begin
        count_d = '0;
        ok_d    = 1'b1;
      end
    endcase
    if (!accept) begin
      ctl.op  = CELL_HOLD;
      count_d = count_q;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] below, above;
    cell_res_t        res_above;
    if (i == 0) begin : g_bot
      assign below = '0;
    end else begin : g_mid_lo
      assign below = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign above     = '0;
      assign res_above = '0;
    end else begin : g_mid_hi
      assign above     = entry_w[i+1];
      assign res_above = res_w[i+1];
    end
    ile_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .below_i     (below),
      .above_i     (above),
      .res_above_i (res_above),
      .entry_o     (entry_w[i]),
      .res_o       (res_w[i])
    );
  end

  assign out_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sweep_d = CntW'(SweepLen);
          state_d = (is_read_d && (SweepLen != 0)) ? ST_SWEEP : ST_DONE;
        end
      end
      ST_SWEEP: begin
        sweep_d = sweep_q - CntW'(1);
        if (sweep_q == CntW'(1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    if (is_find_q) begin
      done_ans = res_w[0].hit ? res_w[0].data : NotFound;
      done_ok  = res_w[0].hit;
    end else if (is_read_q) begin
      done_ans = ok_q ? res_w[0].data : '0;
      done_ok  = ok_q;
    end else begin
      done_ans = ans_q;
      done_ok  = ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sweep_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sweep_q <= sweep_d;
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_read_q <= is_read_d;
      is_find_q <= is_find_d;
      ok_q      <= ok_d;
      ans_q     <= ans_d;
    end
    if (out_load) begin
      rsp_ans_q <= done_ans;
      rsp_cnt_q <= count_q;
      rsp_ok_q  <= done_ok;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.answer      = rsp_ans_q;
  assign rsp_o.entry_count = rsp_cnt_q;
  assign rsp_o.success     = rsp_ok_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("entry count above capacity");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
    else $error("response raised outside done state");

  a_read_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_read_d && (SweepLen != 0) |=> state_q == ST_SWEEP)
    else $error("read transaction skipped the result fold");

  a_index_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && is_read_q && !is_find_q && ok_q |-> res_w[0].hit)
    else $error("valid index read found no cell");
`endif

endmodule

FILE: sim/indexed_list_engine_tb.sv
// Testbench for indexed_list_engine: a directed table, then push-heavy, mixed, drain-heavy
// and mixed random phases, checked against fixed table expectations or an in-bench predictor.
// Depends on ile_pkg, ile_if and the indexed_list_engine RTL.
`timescale 1ns / 1ps

module indexed_list_engine_tb;
  import ile_pkg::*;

  localparam int ListCap    = DefCapacity;
  localparam int CntW       = CntWDef;
  localparam int DirRows    = 25;
  localparam int CycleLimit = 300000;
  localparam int MaxShown   = 40;

  typedef struct packed {
    logic signed [DataW-1:0] answer;
    logic [CntW-1:0]         entry_count;
    logic                    success;
  } list_rsp_t;

  typedef struct packed {
    act_e                    act;
    logic signed [PosW-1:0]  pos;
    logic signed [DataW-1:0] val;
    logic                    fixed_exp;
    list_rsp_t               exp_rsp;
  } dir_row_t;

  typedef enum int {
    PH_FILL,
    PH_MIX,
    PH_DRAIN
  } phase_e;

  logic clk_i;
  logic rst_ni;

  ile_req_if req_ch ();
  ile_rsp_if #(.CNT_W(CntW)) rsp_ch ();

  indexed_list_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  logic signed [DataW-1:0] list_mem [ListCap];
  int                      list_len;
  list_rsp_t               results_due [$];

  int err_count;
  int rsp_count;
  int cycle_cnt;
  int rsp_hold;
  int send_run;
  int recv_run;
  int act_hits [8];
  int refused;
  int full_rejects;
  int peak_len;

  dir_row_t dir_tbl [DirRows];

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Predictor: applies one action to the bench copy of the list.
  function automatic list_rsp_t list_op_result(input act_e a,
                                               input logic signed [PosW-1:0] p,
                                               input logic signed [DataW-1:0] v);
    list_rsp_t r;
    int        pi;
    int        at;
    logic      in_rng;
    r  = '0;
    pi = p;
    in_rng = (pi >= 0) && (pi < list_len);
    case (a)
      ACT_PUSH: begin
        if (list_len < ListCap) begin
          list_mem[list_len] = v;
          list_len++;
          r.success = 1'b1;
        end
        r.answer = list_len;
      end
      ACT_POP: begin
        if (list_len > 0) begin
          list_len--;
          r.answer  = list_mem[list_len];
          r.success = 1'b1;
        end
      end
      ACT_GET: begin
        if (in_rng) begin
          r.answer  = list_mem[pi];
          r.success = 1'b1;
        end
      end
      ACT_SET: begin
        if (in_rng) begin
          list_mem[pi] = v;
          r.answer     = v;
          r.success    = 1'b1;
        end
      end
      ACT_INSERT: begin
        at = (pi < 0) ? 0 : (pi > list_len) ? list_len : pi;
        if (list_len < ListCap) begin
          for (int i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
          list_mem[at] = v;
          list_len++;
          r.success = 1'b1;
        end
        r.answer = list_len;
      end
      ACT_REMOVE: begin
        if (in_rng) begin
          r.answer = list_mem[pi];
          for (int i = pi; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          r.success = 1'b1;
        end
      end
      ACT_FIND: begin
        r.answer = NotFound;
        for (int i = 0; i < list_len; i++) begin
          if (!r.success && list_mem[i] == v) begin
            r.answer  = i;
            r.success = 1'b1;
          end
        end
      end
      default: begin
        list_len  = 0;
        r.success = 1'b1;
      end
    endcase
    r.entry_count = CntW'(list_len);
    return r;
  endfunction

  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic report_mismatch(input string field, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    if (err_count < MaxShown)
      $display("%0t: transaction %0d %s: got %h, want %h", $realtime, rsp_count, field,
               got, want);
    err_count++;
  endtask

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic send_item(input act_e a, input logic signed [PosW-1:0] p,
                           input logic signed [DataW-1:0] v, input logic fixed_exp,
                           input list_rsp_t fexp);
    int        gap;
    list_rsp_t pred;
    gap = draw_wait(send_run);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= a;
    req_ch.position      <= p;
    req_ch.operand_value <= v;
    do @(posedge clk_i); while (!req_ch.ready);
    pred = list_op_result(a, p, v);
    results_due.push_back(fixed_exp ? fexp : pred);
    act_hits[int'(a)]++;
    if (!pred.success) refused++;
    if (!pred.success && (a == ACT_PUSH || a == ACT_INSERT)) full_rejects++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  task automatic gen_item(input phase_e ph, output act_e a,
                          output logic signed [PosW-1:0] p,
                          output logic signed [DataW-1:0] v);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:
        a = (r < 45) ? ACT_PUSH : (r < 75) ? ACT_INSERT : (r < 80) ? ACT_POP :
            (r < 85) ? ACT_GET : (r < 90) ? ACT_SET : (r < 95) ? ACT_FIND : ACT_REMOVE;
      PH_DRAIN:
        a = (r < 35) ? ACT_POP : (r < 65) ? ACT_REMOVE : (r < 75) ? ACT_GET :
            (r < 85) ? ACT_FIND : (r < 92) ? ACT_SET : (r < 97) ? ACT_PUSH : ACT_INSERT;
      default:
        a = (r < 3) ? ACT_CLEAR : act_e'($urandom_range(0, 6));
    endcase
    if ($urandom_range(0, 9) == 0) p = $signed(PosW'($urandom));
    else p = $signed(PosW'($urandom_range(0, list_len + 2))) - 16'sd1;
    r = $urandom_range(0, 99);
    if (list_len > 0 && (r < 40 || (a == ACT_FIND && r < 70)))
      v = list_mem[$urandom_range(0, list_len - 1)];
    else if (r < 70) v = $signed(DataW'($urandom_range(0, 6))) - 64'sd3;
    else v = $signed({$urandom, $urandom});
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               results_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin : rsp_check
    list_rsp_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected transaction", rsp_ch.answer, '0);
      end else begin
        want = results_due.pop_front();
        if (rsp_ch.answer !== want.answer)
          report_mismatch("answer", rsp_ch.answer, want.answer);
        if (rsp_ch.entry_count !== want.entry_count)
          report_mismatch("entry_count", DataW'(rsp_ch.entry_count),
                          DataW'(want.entry_count));
        if (rsp_ch.success !== want.success)
          report_mismatch("success", DataW'(rsp_ch.success), DataW'(want.success));
      end
      rsp_count++;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin : rsp_drive
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (rsp_hold > 0) begin
        stall    = rsp_hold;
        rsp_hold = 0;
      end else begin
        stall = draw_wait(recv_run);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
    end
  end

  initial begin : main_seq
    act_e                    a;
    logic signed [PosW-1:0]  p;
    logic signed [DataW-1:0] v;
    phase_e                  plan_ph [4];
    int                      plan_n [4];

    dir_tbl = '{
      '{ACT_POP,    16'sd0,      64'sd0,                   1'b1, '{64'sd0,  7'd0, 1'b0}},
      '{ACT_GET,    16'sd0,      64'sd0,                   1'b1, '{64'sd0,  7'd0, 1'b0}},
      '{ACT_REMOVE, 16'sd0,      64'sd0,                   1'b1, '{64'sd0,  7'd0, 1'b0}},
      '{ACT_FIND,   16'sd0,      64'sd0,                   1'b1, '{-64'sd1, 7'd0, 1'b0}},
      '{ACT_SET,    16'sd0,      64'sd9,                   1'b1, '{64'sd0,  7'd0, 1'b0}},
      '{ACT_PUSH,   16'sd0,      64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, '{64'sd1,  7'd1, 1'b1}},
      '{ACT_PUSH,   -16'sd1,     64'sh8000_0000_0000_0000, 1'b1, '{64'sd2,  7'd2, 1'b1}},
      '{ACT_INSERT, -16'sd32768, 64'sh5555_5555_5555_5555, 1'b1, '{64'sd3,  7'd3, 1'b1}},
      '{ACT_INSERT, 16'sd32767,  64'shAAAA_AAAA_AAAA_AAAA, 1'b1, '{64'sd4,  7'd4, 1'b1}},
      '{ACT_INSERT, 16'sd2,      64'sd1,                   1'b1, '{64'sd5,  7'd5, 1'b1}},
      '{ACT_GET,    -16'sd1,     64'sd0,                   1'b1, '{64'sd0,  7'd5, 1'b0}},
      '{ACT_GET,    16'sd5,      64'sd0,                   1'b1, '{64'sd0,  7'd5, 1'b0}},
      '{ACT_GET,    16'sd0,      64'sd0,                   1'b0, '0},
      '{ACT_GET,    16'sd4,      64'sd0,                   1'b0, '0},
      '{ACT_FIND,   16'sd0,      64'sh8000_0000_0000_0000, 1'b0, '0},
      '{ACT_PUSH,   16'sd0,      64'sd1,                   1'b1, '{64'sd6,  7'd6, 1'b1}},
      '{ACT_FIND,   16'sd0,      64'sd1,                   1'b0, '0},
      '{ACT_SET,    16'sd32767,  64'sd7,                   1'b1, '{64'sd0,  7'd6, 1'b0}},
      '{ACT_SET,    16'sd1,      -64'sd1,                  1'b0, '0},
      '{ACT_REMOVE, 16'sd0,      64'sd0,                   1'b0, '0},
      '{ACT_REMOVE, -16'sd32768, 64'sd0,                   1'b1, '{64'sd0,  7'd5, 1'b0}},
      '{ACT_FIND,   16'sd0,      64'sd12345,               1'b1, '{-64'sd1, 7'd5, 1'b0}},
      '{ACT_POP,    16'sd0,      64'sd0,                   1'b0, '0},
      '{ACT_CLEAR,  16'sd3,      64'sd5,                   1'b1, '{64'sd0,  7'd0, 1'b1}},
      '{ACT_POP,    16'sd0,      64'sd0,                   1'b1, '{64'sd0,  7'd0, 1'b0}}
    };
    plan_ph = '{PH_FILL, PH_MIX, PH_DRAIN, PH_MIX};
    plan_n  = '{120, 150, 90, 165};

    list_len = 0;
    for (int i = 0; i < ListCap; i++) list_mem[i] = '0;
    rst_ni               <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.action        <= ACT_PUSH;
    req_ch.position      <= '0;
    req_ch.operand_value <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++)
      send_item(dir_tbl[r].act, dir_tbl[r].pos, dir_tbl[r].val, dir_tbl[r].fixed_exp,
                dir_tbl[r].exp_rsp);

    for (int k = 0; k < 4; k++) begin
      wait_drained();
      if (k == 1) rsp_hold = 400;
      for (int n = 0; n < plan_n[k]; n++) begin
        if (k == 0 && n == 40) rsp_hold = 250;
        gen_item(plan_ph[k], a, p, v);
        send_item(a, p, v, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (ListCap + 16) @(posedge clk_i);

    $display("Ran %0d transactions in %0d cycles: push %0d pop %0d get %0d set %0d",
             rsp_count, cycle_cnt, act_hits[0], act_hits[1], act_hits[2], act_hits[3]);
    $display("insert %0d remove %0d find %0d clear %0d; %0d refused, %0d full, peak %0d",
             act_hits[4], act_hits[5], act_hits[6], act_hits[7], refused, full_rejects,
             peak_len);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/ile_pkg.sv
hdl/ile_if.sv
hdl/ile_cell.sv
hdl/indexed_list_engine.sv
sim/indexed_list_engine_tb.sv
